// ===== hw/rtl/usps_pkg.sv =====
package usps_pkg;

   localparam int LINE_LIMIT_DEF = 32;

   localparam int BYTE_W     = 8;
   localparam int OFFSET_W   = 11;
   localparam int TENTHS_W   = 15;
   localparam int MAG_W      = 14;
   localparam int DIGIT_W    = 4;
   localparam int DIGITS     = 4;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CH_MINUS   = 8'd45;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;

   localparam logic [0:0] FUNC_TICK = 1'b0;

   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTIFY_CMD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY_RSP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_CMD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OK_RSP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CMD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMID_CMD    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_OFFSET  = 3'd6;

   localparam logic [BYTE_W-1:0]   IDENTIFY_CMD_RST = 8'd73;
   localparam logic [BYTE_W-1:0]   IDENTITY_RSP_RST = 8'd73;
   localparam logic [BYTE_W-1:0]   UPDATE_CMD_RST   = 8'd85;
   localparam logic [BYTE_W-1:0]   OK_RSP_RST       = 8'd79;
   localparam logic [BYTE_W-1:0]   TEMP_CMD_RST     = 8'd84;
   localparam logic [BYTE_W-1:0]   HUMID_CMD_RST    = 8'd72;
   localparam logic [OFFSET_W-1:0] TEMP_OFFSET_RST  = 11'd0;

   // line positions of the sign and the four digits in "T+000.0"
   localparam int POS_SIGN = 1;
   localparam int POS_D0   = 2;
   localparam int POS_D1   = 3;
   localparam int POS_D2   = 4;
   localparam int POS_D3   = 6;

   localparam logic [MAG_W-1:0] W_THOUSAND = 14'd1000;
   localparam logic [MAG_W-1:0] W_HUNDRED  = 14'd100;
   localparam logic [MAG_W-1:0] W_TEN      = 14'd10;

   typedef enum logic [6:0] {
      PH_IDLE       = 7'b0000001,
      PH_WAIT_ID    = 7'b0000010,
      PH_SKIP_LINE  = 7'b0000100,
      PH_UPD_FIRST  = 7'b0001000,
      PH_UPD_SECOND = 7'b0010000,
      PH_WAIT_T     = 7'b0100000,
      PH_WAIT_H     = 7'b1000000
   } phase_type;

   typedef logic [DIGIT_W-1:0] digit_type;

   function automatic digit_type digit_of(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] d;
      d = c - CH_ZERO;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return d[DIGIT_W-1:0];
      end
      return '0;
   endfunction

endpackage

// ===== hw/rtl/uart_sensor_poll_sequencer_top.sv =====
// An item passes through the input register; its result, if any, is loaded into the result
// register, which drives rsp_valid.
// Throughput: one item per cycle; an item with no result never waits on the output side.
// An item with a result waits in the input register only while the result register is
// full and not being taken.
// Reset (synchronous, active high): phase idle, line state cleared, status no data,
// configuration registers at their default values, both pipeline registers empty.
module uart_sensor_poll_sequencer_top #(
   parameter int LINE_LIMIT = usps_pkg::LINE_LIMIT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_func,
   input  logic [usps_pkg::BYTE_W-1:0]             req_rx_byte,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_tx_valid,
   output logic [usps_pkg::BYTE_W-1:0]             rsp_tx_byte,
   output logic                                    rsp_update_begin,
   output logic                                    rsp_reading_valid,
   output logic signed [usps_pkg::TENTHS_W-1:0]    rsp_temperature_tenths,
   output logic signed [usps_pkg::TENTHS_W-1:0]    rsp_humidity_tenths,
   output logic [usps_pkg::STATUS_W-1:0]           rsp_reading_status,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [usps_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [usps_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import usps_pkg::*;

   localparam int PW = $clog2(LINE_LIMIT + 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_LIMIT);

   // configuration
   logic [BYTE_W-1:0]          identify_cmd_ff;
   logic [BYTE_W-1:0]          identity_rsp_ff;
   logic [BYTE_W-1:0]          update_cmd_ff;
   logic [BYTE_W-1:0]          ok_rsp_ff;
   logic [BYTE_W-1:0]          temp_cmd_ff;
   logic [BYTE_W-1:0]          humid_cmd_ff;
   logic signed [OFFSET_W-1:0] temp_offset_ff;

   // input register
   logic               item_valid_ff;
   logic               item_func_ff;
   logic [BYTE_W-1:0]  item_byte_ff;

   // sequencer state
   phase_type                  phase_ff, phase_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic                       neg_ff, neg_in;
   digit_type                  dig_ff [DIGITS];
   digit_type                  dig_in [DIGITS];
   logic signed [TENTHS_W-1:0] held_ff, held_in;

   // result register
   logic                       out_valid_ff;
   logic                       out_tx_valid_ff, out_tx_valid_in;
   logic [BYTE_W-1:0]          out_tx_byte_ff, out_tx_byte_in;
   logic                       out_begin_ff, out_begin_in;
   logic                       out_reading_ff, out_reading_in;
   logic signed [TENTHS_W-1:0] out_temp_ff, out_temp_in;
   logic signed [TENTHS_W-1:0] out_humid_ff, out_humid_in;
   logic [STATUS_W-1:0]        out_status_ff, out_status_in;

   logic                       res_fire;
   logic                       advance;
   logic [MAG_W-1:0]           line_mag;
   logic signed [TENTHS_W-1:0] mag_s;
   logic signed [TENTHS_W-1:0] line_val;
   logic signed [TENTHS_W-1:0] temp_sum;

   assign line_mag = MAG_W'(dig_ff[0]) * W_THOUSAND + MAG_W'(dig_ff[1]) * W_HUNDRED
                   + MAG_W'(dig_ff[2]) * W_TEN + MAG_W'(dig_ff[3]);
   assign mag_s    = TENTHS_W'(line_mag);
   assign line_val = neg_ff ? -mag_s : mag_s;
   assign temp_sum = line_val + TENTHS_W'(temp_offset_ff);

   always_comb begin
      phase_in        = phase_ff;
      status_in       = status_ff;
      pos_in          = pos_ff;
      neg_in          = neg_ff;
      dig_in          = dig_ff;
      held_in         = held_ff;
      res_fire        = 1'b0;
      out_tx_valid_in = 1'b0;
      out_tx_byte_in  = '0;
      out_begin_in    = 1'b0;
      out_reading_in  = 1'b0;
      out_temp_in     = '0;
      out_humid_in    = '0;
      out_status_in   = STATUS_NONE;

      if (item_func_ff == FUNC_TICK) begin
         if (phase_ff == PH_IDLE) begin
            status_in       = STATUS_NONE;
            phase_in        = PH_WAIT_ID;
            res_fire        = 1'b1;
            out_tx_valid_in = 1'b1;
            out_tx_byte_in  = identify_cmd_ff;
         end
      end else begin
         case (phase_ff)
            PH_WAIT_ID: begin
               if (item_byte_ff == identity_rsp_ff) begin
                  phase_in = PH_SKIP_LINE;
                  pos_in   = '0;
                  neg_in   = 1'b0;
                  dig_in   = '{default: '0};
               end else begin
                  phase_in        = PH_UPD_FIRST;
                  res_fire        = 1'b1;
                  out_tx_valid_in = 1'b1;
                  out_tx_byte_in  = update_cmd_ff;
                  out_begin_in    = 1'b1;
               end
            end
            PH_SKIP_LINE: begin
               if (item_byte_ff == CH_NEWLINE) begin
                  phase_in        = PH_UPD_FIRST;
                  res_fire        = 1'b1;
                  out_tx_valid_in = 1'b1;
                  out_tx_byte_in  = update_cmd_ff;
                  out_begin_in    = 1'b1;
               end
            end
            PH_UPD_FIRST: begin
               status_in = (item_byte_ff == ok_rsp_ff) ? STATUS_GOOD : STATUS_ERR;
               phase_in  = PH_UPD_SECOND;
            end
            PH_UPD_SECOND: begin
               pos_in          = '0;
               neg_in          = 1'b0;
               dig_in          = '{default: '0};
               phase_in        = PH_WAIT_T;
               res_fire        = 1'b1;
               out_tx_valid_in = 1'b1;
               out_tx_byte_in  = temp_cmd_ff;
            end
            PH_WAIT_T, PH_WAIT_H: begin
               if (item_byte_ff != CH_NEWLINE) begin
                  // drop bytes once the line is past its limit
                  if (pos_ff < POS_LIMIT) begin
                     case (pos_ff)
                        PW'(POS_SIGN): neg_in    = (item_byte_ff == CH_MINUS);
                        PW'(POS_D0):   dig_in[0] = digit_of(item_byte_ff);
                        PW'(POS_D1):   dig_in[1] = digit_of(item_byte_ff);
                        PW'(POS_D2):   dig_in[2] = digit_of(item_byte_ff);
                        PW'(POS_D3):   dig_in[3] = digit_of(item_byte_ff);
                        default:       ;
                     endcase
                     pos_in = pos_ff + PW'(1);
                  end
               end else begin
                  pos_in   = '0;
                  neg_in   = 1'b0;
                  dig_in   = '{default: '0};
                  res_fire = 1'b1;
                  if (phase_ff == PH_WAIT_T) begin
                     held_in         = temp_sum;
                     phase_in        = PH_WAIT_H;
                     out_tx_valid_in = 1'b1;
                     out_tx_byte_in  = humid_cmd_ff;
                  end else begin
                     phase_in       = PH_IDLE;
                     out_reading_in = 1'b1;
                     out_temp_in    = held_ff;
                     out_humid_in   = line_val;
                     out_status_in  = status_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // hold the item while its result cannot enter the result register
   assign advance   = item_valid_ff && (!res_fire || !out_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         identify_cmd_ff <= IDENTIFY_CMD_RST;
         identity_rsp_ff <= IDENTITY_RSP_RST;
         update_cmd_ff   <= UPDATE_CMD_RST;
         ok_rsp_ff       <= OK_RSP_RST;
         temp_cmd_ff     <= TEMP_CMD_RST;
         humid_cmd_ff    <= HUMID_CMD_RST;
         temp_offset_ff  <= TEMP_OFFSET_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDENTIFY_CMD: identify_cmd_ff <= csr_wdata[BYTE_W-1:0];
            CSR_IDENTITY_RSP: identity_rsp_ff <= csr_wdata[BYTE_W-1:0];
            CSR_UPDATE_CMD:   update_cmd_ff   <= csr_wdata[BYTE_W-1:0];
            CSR_OK_RSP:       ok_rsp_ff       <= csr_wdata[BYTE_W-1:0];
            CSR_TEMP_CMD:     temp_cmd_ff     <= csr_wdata[BYTE_W-1:0];
            CSR_HUMID_CMD:    humid_cmd_ff    <= csr_wdata[BYTE_W-1:0];
            CSR_TEMP_OFFSET:  temp_offset_ff  <= signed'(csr_wdata[OFFSET_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_func_ff <= req_func;
         item_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         status_ff <= STATUS_NONE;
         pos_ff    <= '0;
         neg_ff    <= 1'b0;
         dig_ff    <= '{default: '0};
         held_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         pos_ff    <= pos_in;
         neg_ff    <= neg_in;
         dig_ff    <= dig_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_fire) begin
         out_tx_valid_ff <= out_tx_valid_in;
         out_tx_byte_ff  <= out_tx_byte_in;
         out_begin_ff    <= out_begin_in;
         out_reading_ff  <= out_reading_in;
         out_temp_ff     <= out_temp_in;
         out_humid_ff    <= out_humid_in;
         out_status_ff   <= out_status_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_tx_valid           = out_tx_valid_ff;
   assign rsp_tx_byte            = out_tx_byte_ff;
   assign rsp_update_begin       = out_begin_ff;
   assign rsp_reading_valid      = out_reading_ff;
   assign rsp_temperature_tenths = out_temp_ff;
   assign rsp_humidity_tenths    = out_humid_ff;
   assign rsp_reading_status     = out_status_ff;

endmodule
